// File: design/vts_pkg.sv
// Shared constants, codes and the fixed-point lerp for the voxel trilinear sampler.
// No dependencies; vts_blend and the top level import this package.
`default_nettype none
package vts_pkg;

  localparam int GRID_SIDE  = 32;
  localparam int FRAC_BITS  = 8;
  localparam int DENS_BITS  = 16;
  localparam int COORD_BITS = 15;
  localparam int ADDR_BITS  = $clog2(GRID_SIDE * GRID_SIDE * GRID_SIDE);
  localparam int SIZE_BITS  = 6;
  localparam int INT_BITS   = COORD_BITS - FRAC_BITS;   // signed integer part
  localparam int NB_BITS    = INT_BITS + 1;             // neighbour coordinate
  localparam int ROW_BITS   = 2 * SIZE_BITS + 1;        // y + sy*z
  localparam int CORNERS    = 8;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;
  localparam logic [1:0] CFG_MARGIN = 2'd3;

  typedef logic [DENS_BITS-1:0] dens_t;
  typedef logic [FRAC_BITS-1:0] frac_t;

  // Truncating lerp: (a*(ONE-t) + b*t) >> FRAC_BITS
  function automatic dens_t lerp(input dens_t a, input dens_t b, input frac_t t);
    logic [FRAC_BITS:0]                 w;
    logic [DENS_BITS+FRAC_BITS+1:0]     s;
    w = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, t};
    s = (DENS_BITS+FRAC_BITS+2)'(a) * (DENS_BITS+FRAC_BITS+2)'(w)
      + (DENS_BITS+FRAC_BITS+2)'(b) * (DENS_BITS+FRAC_BITS+2)'(t);
    return s[FRAC_BITS +: DENS_BITS];
  endfunction

endpackage
`default_nettype wire

// File: design/vts_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Generic; no package dependency.
`default_nettype none
module vts_ram #(
  parameter int AW = 15,
  parameter int DW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: design/vts_blend.sv
// Three-stage trilinear blend: x lerps, then y, then z, one register per stage.
// Depends on vts_pkg for widths and the lerp function.
`default_nettype none
module vts_blend
  import vts_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [CORNERS-1:0][DENS_BITS-1:0] vox_i,
  input  wire logic [CORNERS-1:0]          nv_i,
  input  wire logic [2:0][FRAC_BITS-1:0]   fr_i,
  output logic      [DENS_BITS-1:0]        density_o
);

  logic [CORNERS-1:0][DENS_BITS-1:0] v;
  logic [3:0][DENS_BITS-1:0] x_q;
  logic [1:0][DENS_BITS-1:0] y_q;
  logic [1:0][FRAC_BITS-1:0] frx_q;
  logic [FRAC_BITS-1:0]      fry_q;

  // Zero corners outside the grid
  always_comb begin
    for (int k = 0; k < CORNERS; k++) begin
      v[k] = nv_i[k] ? vox_i[k] : '0;
    end
  end

  // Blend along x, then y, then z
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 4; j++) begin
        x_q[j] <= lerp(v[2*j], v[2*j+1], fr_i[0]);
      end
      frx_q     <= fr_i[2:1];
      y_q[0]    <= lerp(x_q[0], x_q[1], frx_q[0]);
      y_q[1]    <= lerp(x_q[2], x_q[3], frx_q[0]);
      fry_q     <= frx_q[1];
      density_o <= lerp(y_q[0], y_q[1], fry_q);
    end
  end

endmodule
`default_nettype wire

// File: design/voxel_trilinear_sampler.sv
// Voxel density store with a trilinear query port: top level.
// Depends on vts_pkg, vts_ram and vts_blend.
//
// Usage: one input channel (valid/ready) carries either a voxel write
// (opcode 0: voxel_index, voxel_value) or a query (opcode 1: coord_x/y/z,
// signed with 8 fraction bits). Every transaction gives one result on the
// output channel: the blended density and a negative-coordinate error flag
// (both zero for writes). Registers (grid sizes, snap margin) are written
// through the separate cfg port, only while the block is idle: the user must
// ensure this, as the block itself does not enforce it. Seven register
// stages lie between input acceptance and a valid result, the first loaded at
// the accepting edge. Throughput is one transaction per cycle while no result
// waits unaccepted; the eight neighbour voxels come from eight replicated store
// copies, each with one read port, all written together. Writes and reads meet
// the store in the same stage, so a query sees every earlier write.
// The pipeline advances as one unit: while a result waits unaccepted, the
// whole pipeline and the input hold; otherwise a new item enters each cycle.
// Reset empties the pipeline and loads default registers; store contents are
// undefined until written.
`default_nettype none
module voxel_trilinear_sampler
  import vts_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  opcode_i,
  input  wire logic [ADDR_BITS-1:0]  voxel_index_i,
  input  wire logic [DENS_BITS-1:0]  voxel_value_i,
  input  wire logic signed [COORD_BITS-1:0] coord_x_i,
  input  wire logic signed [COORD_BITS-1:0] coord_y_i,
  input  wire logic signed [COORD_BITS-1:0] coord_z_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [DENS_BITS-1:0]  density_out_o,
  output logic                       negative_error_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [7:0]            cfg_data_i
);

  logic [SIZE_BITS-1:0] size_q [3];
  logic [7:0]           margin_q;
  logic                 advance;
  logic [7:1]           vld_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= SIZE_BITS'(GRID_SIDE);
      size_q[1] <= SIZE_BITS'(GRID_SIDE);
      size_q[2] <= SIZE_BITS'(GRID_SIDE);
      margin_q  <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SIZE_X: size_q[0] <= cfg_data_i[SIZE_BITS-1:0];
        CFG_SIZE_Y: size_q[1] <= cfg_data_i[SIZE_BITS-1:0];
        CFG_SIZE_Z: size_q[2] <= cfg_data_i[SIZE_BITS-1:0];
        CFG_MARGIN: margin_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline moves as one unit unless the result is stalled
  assign advance    = !vld_q[7] || out_ready_i;
  assign in_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[6:1], in_valid_i};
    end
  end

  // Stage 1: snap, split into floor and fraction
  logic [COORD_BITS-1:0] cin [3];
  logic [COORD_BITS-1:0] cs  [3];
  logic signed [COORD_BITS:0] csum [3];

  assign cin[0] = coord_x_i;
  assign cin[1] = coord_y_i;
  assign cin[2] = coord_z_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      csum[a] = $signed({cin[a][COORD_BITS-1], cin[a]})
              + $signed({{(COORD_BITS-7){1'b0}}, margin_q});
      cs[a]   = (cin[a][COORD_BITS-1] && (csum[a] > 0)) ? '0 : cin[a];
    end
  end

  logic                  s1_op_q;
  logic [ADDR_BITS-1:0]  s1_widx_q;
  logic [DENS_BITS-1:0]  s1_wval_q;
  logic [NB_BITS-1:0]    s1_lo_q [3];
  logic [2:0][FRAC_BITS-1:0] s1_fr_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_op_q   <= opcode_i;
      s1_widx_q <= voxel_index_i;
      s1_wval_q <= voxel_value_i;
      for (int a = 0; a < 3; a++) begin
        s1_lo_q[a] <= {cs[a][COORD_BITS-1], cs[a][COORD_BITS-1:FRAC_BITS]};
        s1_fr_q[a] <= cs[a][FRAC_BITS-1:0];
      end
    end
  end

  // Stage 2: neighbour checks and row offset y + sy*z
  logic [NB_BITS-1:0]   nb  [CORNERS][3];
  logic [CORNERS-1:0]   beyond, neg;
  logic                 s2_op_q, s2_err_q;
  logic [ADDR_BITS-1:0] s2_widx_q;
  logic [DENS_BITS-1:0] s2_wval_q;
  logic [CORNERS-1:0]   s2_nv_q;
  logic [ROW_BITS-1:0]  s2_t_q [CORNERS];
  logic [SIZE_BITS-1:0] s2_x_q [CORNERS];
  logic [2:0][FRAC_BITS-1:0] s2_fr_q;

  always_comb begin
    for (int k = 0; k < CORNERS; k++) begin
      beyond[k] = 1'b0;
      neg[k]    = 1'b0;
      for (int a = 0; a < 3; a++) begin
        nb[k][a] = s1_lo_q[a] + NB_BITS'((k >> a) & 1);
        if (!nb[k][a][NB_BITS-1] && (nb[k][a][NB_BITS-2:0] >= (NB_BITS-1)'(size_q[a]))) begin
          beyond[k] = 1'b1;
        end
        if (nb[k][a][NB_BITS-1]) begin
          neg[k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_op_q   <= s1_op_q;
      s2_widx_q <= s1_widx_q;
      s2_wval_q <= s1_wval_q;
      s2_fr_q   <= s1_fr_q;
      s2_err_q  <= (s1_op_q == OP_QUERY) && |(neg & ~beyond);
      for (int k = 0; k < CORNERS; k++) begin
        s2_nv_q[k] <= (s1_op_q == OP_QUERY) && !beyond[k] && !neg[k];
        s2_x_q[k]  <= nb[k][0][SIZE_BITS-1:0];
        s2_t_q[k]  <= ROW_BITS'(nb[k][1][SIZE_BITS-1:0])
                    + ROW_BITS'(size_q[1]) * ROW_BITS'(nb[k][2][SIZE_BITS-1:0]);
      end
    end
  end

  // Stage 3: linear address x + sx*t, wrapped to the store depth
  logic                 s3_op_q, s3_err_q;
  logic [ADDR_BITS-1:0] s3_widx_q;
  logic [DENS_BITS-1:0] s3_wval_q;
  logic [CORNERS-1:0]   s3_nv_q;
  logic [ADDR_BITS-1:0] s3_addr_q [CORNERS];
  logic [2:0][FRAC_BITS-1:0] s3_fr_q;
  logic [SIZE_BITS+ROW_BITS-1:0] prod [CORNERS];

  always_comb begin
    for (int k = 0; k < CORNERS; k++) begin
      prod[k] = (SIZE_BITS+ROW_BITS)'(s2_x_q[k])
              + (SIZE_BITS+ROW_BITS)'(size_q[0]) * (SIZE_BITS+ROW_BITS)'(s2_t_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_op_q   <= s2_op_q;
      s3_err_q  <= s2_err_q;
      s3_widx_q <= s2_widx_q;
      s3_wval_q <= s2_wval_q;
      s3_nv_q   <= s2_nv_q;
      s3_fr_q   <= s2_fr_q;
      for (int k = 0; k < CORNERS; k++) begin
        s3_addr_q[k] <= prod[k][ADDR_BITS-1:0];
      end
    end
  end

  // Stage 4: store access, one copy per corner, all written together
  logic [CORNERS-1:0][DENS_BITS-1:0] rdata;
  logic                 mem_we;
  logic                 s4_op_q, s4_err_q;
  logic [CORNERS-1:0]   s4_nv_q;
  logic [2:0][FRAC_BITS-1:0] s4_fr_q;

  assign mem_we = advance && vld_q[3] && (s3_op_q == OP_WRITE);

  for (genvar k = 0; k < CORNERS; k++) begin : g_bank
    vts_ram #(
      .AW(ADDR_BITS),
      .DW(DENS_BITS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (mem_we),
      .waddr_i (s3_widx_q),
      .wdata_i (s3_wval_q),
      .re_i    (advance),
      .raddr_i (s3_addr_q[k]),
      .rdata_o (rdata[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s4_op_q  <= s3_op_q;
      s4_err_q <= s3_err_q;
      s4_nv_q  <= s3_nv_q;
      s4_fr_q  <= s3_fr_q;
    end
  end

  // Stages 5 to 7: blend
  vts_blend u_blend (
    .clk_i     (clk_i),
    .en_i      (advance),
    .vox_i     (rdata),
    .nv_i      (s4_nv_q),
    .fr_i      (s4_fr_q),
    .density_o (density_out_o)
  );

  // Carry the flag and opcode alongside the blend
  logic [2:0] err_q, op_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      err_q <= {err_q[1:0], s4_err_q};
      op_q  <= {op_q[1:0], s4_op_q};
    end
  end

  assign negative_error_o = err_q[2];
  assign out_valid_o      = vld_q[7];

  // Checks
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[7] && op_q[2] == OP_WRITE) |-> (density_out_o == '0 && !negative_error_o))
    else $error("write transaction produced a non-zero result");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(vld_q))
    else $error("pipeline moved while the result was stalled");

  a_no_write_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (vld_q[3] && advance))
    else $error("store written outside a live write transaction");

endmodule
`default_nettype wire
